@@ design/gbte_pkg.sv @@
// ----------------------------------------------------------------------------
// Gap buffer editor package
// Sizes, action and result codes, and the types shared by the editor's
// modules.
// ----------------------------------------------------------------------------
package gbte_pkg;

  // Character store size; a power of two so that the gap addresses wrap.
  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = $clog2(CAPACITY);
  // Lengths must hold CAPACITY itself.
  localparam int LEN_W    = ADDR_W + 1;
  // Fixed field widths of the channels.
  localparam int CNT_W    = 11;
  localparam int CHAR_W   = 8;
  localparam int SHOW_W   = 5;
  localparam int MIX_W    = (LEN_W > CNT_W) ? LEN_W : CNT_W;

  localparam logic [SHOW_W-1:0] SHOW_RESET = SHOW_W'(10);
  localparam logic [SHOW_W-1:0] SHOW_MAX   = SHOW_W'(16);

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_DELETE = 2'd1;
  localparam logic [1:0] ACT_LEFT   = 2'd2;
  localparam logic [1:0] ACT_RIGHT  = 2'd3;

  localparam logic [1:0] K_DELETED = 2'd0;
  localparam logic [1:0] K_SHOWN   = 2'd1;
  localparam logic [1:0] K_EMPTY   = 2'd2;
  localparam logic [1:0] K_FULL    = 2'd3;

  typedef struct packed {
    logic [1:0]        kind;
    logic [CNT_W-1:0]  deleted;
    logic [CHAR_W-1:0] char_out;
    logic              last;
  } res_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CHAR_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  // Smaller of a requested count and the characters available.
  function automatic logic [LEN_W-1:0] clamp_count(input logic [CNT_W-1:0] req,
                                                   input logic [LEN_W-1:0] avail);
    logic [MIX_W-1:0] r;
    logic [MIX_W-1:0] a;
    r = MIX_W'(req);
    a = MIX_W'(avail);
    return (r < a) ? LEN_W'(r) : avail;
  endfunction

endpackage

@@ design/gbte_ifs.sv @@
// ----------------------------------------------------------------------------
// Gap buffer editor channels
// Valid/ready channel interfaces for the command items and the result items.
// ----------------------------------------------------------------------------
interface gbte_in_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   action;
  logic [gbte_pkg::CHAR_W-1:0]  char_in;
  logic [gbte_pkg::CNT_W-1:0]   count;

  modport source (output valid, action, char_in, count, input ready);
  modport sink   (input valid, action, char_in, count, output ready);
endinterface

interface gbte_out_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   kind;
  logic [gbte_pkg::CNT_W-1:0]   deleted;
  logic [gbte_pkg::CHAR_W-1:0]  char_out;
  logic                         last;

  modport source (output valid, kind, deleted, char_out, last, input ready);
  modport sink   (input valid, kind, deleted, char_out, last, output ready);
endinterface

@@ design/gbte_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered and held while
// no read is issued.
// ----------------------------------------------------------------------------
module gbte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/gbte_ctrl.sv @@
// ----------------------------------------------------------------------------
// Gap buffer editor sequencer
// Holds the cursor lengths, carries out each command by reading and writing
// the character store, and produces the result items.
// ----------------------------------------------------------------------------
module gbte_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  gbte_in_if.sink                    in_ch,
  input  logic [gbte_pkg::SHOW_W-1:0] show_n,
  output gbte_pkg::mem_req_t         mem_req,
  input  logic [gbte_pkg::CHAR_W-1:0] mem_rdata,
  output gbte_pkg::res_t             res,
  output logic                       res_valid,
  input  logic                       res_ready
);
  import gbte_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_EMIT, S_MV_RD, S_MV_WR, S_SH_SET, S_SH_RD, S_SH_OUT
  } state_t;

  state_t            state_r, state_nxt;
  logic [LEN_W-1:0]  left_r, left_nxt;
  logic [LEN_W-1:0]  right_r, right_nxt;
  logic              dir_left_r, dir_left_nxt;
  logic [LEN_W-1:0]  cnt_r, cnt_nxt;
  logic [1:0]        kind_r, kind_nxt;
  logic [CNT_W-1:0]  del_r, del_nxt;
  logic [SHOW_W-1:0] sh_n_r, sh_n_nxt;
  logic [SHOW_W-1:0] sh_i_r, sh_i_nxt;
  logic [LEN_W-1:0]  sh_base_r, sh_base_nxt;

  logic [LEN_W:0]    used;
  logic [LEN_W-1:0]  n_cnt;
  logic [LEN_W-1:0]  n_show;
  logic              sh_last;

  assign used    = (LEN_W+1)'(left_r) + (LEN_W+1)'(right_r);
  assign sh_last = ((sh_i_r + SHOW_W'(1)) == sh_n_r);
  assign n_show  = (LEN_W'(show_n) < left_r) ? LEN_W'(show_n) : left_r;

  always_comb begin
    state_nxt    = state_r;
    left_nxt     = left_r;
    right_nxt    = right_r;
    dir_left_nxt = dir_left_r;
    cnt_nxt      = cnt_r;
    kind_nxt     = kind_r;
    del_nxt      = del_r;
    sh_n_nxt     = sh_n_r;
    sh_i_nxt     = sh_i_r;
    sh_base_nxt  = sh_base_r;
    mem_req      = '0;
    res          = '0;
    res_valid    = 1'b0;
    in_ch.ready  = (state_r == S_IDLE);
    n_cnt        = clamp_count(in_ch.count,
                               (in_ch.action == ACT_LEFT) ? left_r : right_r);

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          case (in_ch.action)
            ACT_INSERT: begin
              if (used >= (LEN_W+1)'(CAPACITY)) begin
                kind_nxt  = K_FULL;
                del_nxt   = '0;
                state_nxt = S_EMIT;
              end else begin
                mem_req.we    = 1'b1;
                mem_req.waddr = left_r[ADDR_W-1:0];
                mem_req.wdata = in_ch.char_in;
                left_nxt      = left_r + LEN_W'(1);
              end
            end
            ACT_DELETE: begin
              n_cnt     = clamp_count(in_ch.count, left_r);
              left_nxt  = left_r - n_cnt;
              kind_nxt  = K_DELETED;
              del_nxt   = CNT_W'(n_cnt);
              state_nxt = S_EMIT;
            end
            default: begin
              dir_left_nxt = (in_ch.action == ACT_LEFT);
              cnt_nxt      = n_cnt;
              state_nxt    = (n_cnt == '0) ? S_SH_SET : S_MV_RD;
            end
          endcase
        end
      end

      S_EMIT: begin
        res_valid   = 1'b1;
        res.kind    = kind_r;
        res.deleted = del_r;
        res.last    = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      S_MV_RD: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = dir_left_r ? ADDR_W'(left_r - LEN_W'(1))
                                   : ADDR_W'(LEN_W'(CAPACITY) - right_r);
        state_nxt     = S_MV_WR;
      end

      S_MV_WR: begin
        mem_req.we    = 1'b1;
        mem_req.wdata = mem_rdata;
        if (dir_left_r) begin
          mem_req.waddr = ADDR_W'(LEN_W'(CAPACITY) - (right_r + LEN_W'(1)));
          left_nxt      = left_r - LEN_W'(1);
          right_nxt     = right_r + LEN_W'(1);
        end else begin
          mem_req.waddr = left_r[ADDR_W-1:0];
          left_nxt      = left_r + LEN_W'(1);
          right_nxt     = right_r - LEN_W'(1);
        end
        cnt_nxt   = cnt_r - LEN_W'(1);
        state_nxt = (cnt_r == LEN_W'(1)) ? S_SH_SET : S_MV_RD;
      end

      S_SH_SET: begin
        if (n_show == '0) begin
          kind_nxt  = K_EMPTY;
          del_nxt   = '0;
          state_nxt = S_EMIT;
        end else begin
          sh_n_nxt    = SHOW_W'(n_show);
          sh_i_nxt    = '0;
          sh_base_nxt = left_r - n_show;
          state_nxt   = S_SH_RD;
        end
      end

      S_SH_RD: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = ADDR_W'(sh_base_r + LEN_W'(sh_i_r));
        state_nxt     = S_SH_OUT;
      end

      S_SH_OUT: begin
        res_valid    = 1'b1;
        res.kind     = K_SHOWN;
        res.char_out = mem_rdata;
        res.last     = sh_last;
        if (res_ready) begin
          if (sh_last) begin
            state_nxt = S_IDLE;
          end else begin
            sh_i_nxt  = sh_i_r + SHOW_W'(1);
            state_nxt = S_SH_RD;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      left_r  <= '0;
      right_r <= '0;
    end else begin
      state_r <= state_nxt;
      left_r  <= left_nxt;
      right_r <= right_nxt;
    end
    dir_left_r <= dir_left_nxt;
    cnt_r      <= cnt_nxt;
    kind_r     <= kind_nxt;
    del_r      <= del_nxt;
    sh_n_r     <= sh_n_nxt;
    sh_i_r     <= sh_i_nxt;
    sh_base_r  <= sh_base_nxt;
  end

endmodule

@@ design/gap_buffer_text_editor_unit.sv @@
// ----------------------------------------------------------------------------
// Gap buffer text editor
// Text buffer with a cursor, held as a gap buffer in one character RAM.
// ----------------------------------------------------------------------------
// Sequence: an insert writes its character straight into the RAM; a delete or a
//   full insert passes its result through the emit state and the output register.
//   A move copies each moved character across the gap (RAM read, then write),
//   sets up the view, then reads and sends each shown one, or one empty result.
// Commands are taken one at a time, only while the sequencer is idle.
// Reset: rst_n (synchronous, active low) empties the buffer, sets show_len to 10.
module gap_buffer_text_editor_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  gbte_in_if.sink                     in_ch,
  gbte_out_if.source                  out_ch,
  input  logic                        cfg_we,
  input  logic [gbte_pkg::SHOW_W-1:0] cfg_data
);
  import gbte_pkg::*;

  // The show length register. Values above sixteen are saturated here, so the
  // sequencer only ever sees a length it can index with its counters.
  logic [SHOW_W-1:0] show_len_r;
  logic [SHOW_W-1:0] show_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      show_len_r <= SHOW_RESET;
    end else if (cfg_we) begin
      show_len_r <= cfg_data;
    end
  end

  assign show_n = (show_len_r > SHOW_MAX) ? SHOW_MAX : show_len_r;

  // The character store: one write port and one registered read port, shared
  // by inserts, the copies across the gap and the reads of the shown view.
  // It is not cleared at reset; only entries that were written are ever read.
  mem_req_t          mem_req;
  logic [CHAR_W-1:0] mem_rdata;

  gbte_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  // The sequencer owns the cursor lengths and walks each command through the
  // RAM, at most one character access per cycle.
  res_t res;
  logic res_valid;
  logic res_ready;

  gbte_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .show_n    (show_n),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .res       (res),
    .res_valid (res_valid),
    .res_ready (res_ready)
  );

  // Output register. It parts the sequencer from the consumer: a finished
  // result waits here while the sequencer goes back for the next command.
  // A new result is taken whenever the register is empty or is being emptied
  // by a transfer in the same cycle.
  logic out_valid_r;
  res_t out_res_r;

  assign res_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.kind     = out_res_r.kind;
  assign out_ch.deleted  = out_res_r.deleted;
  assign out_ch.char_out = out_res_r.char_out;
  assign out_ch.last     = out_res_r.last;

endmodule

@@ design/gbte_chk.sv @@
// ----------------------------------------------------------------------------
// Gap buffer editor checker
// Port-level checks on the editor's command and result channels.
// ----------------------------------------------------------------------------
module gbte_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [1:0]                  in_action,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [1:0]                  out_kind,
  input logic [gbte_pkg::CNT_W-1:0]  out_deleted,
  input logic [gbte_pkg::CHAR_W-1:0] out_char_out,
  input logic                        out_last
);
  import gbte_pkg::*;

  // A stalled result holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
      $stable(out_deleted) && $stable(out_char_out) && $stable(out_last))
    else $error("result changed while stalled");

  // Every command other than an insert keeps the sequencer busy afterwards.
  a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_action != ACT_INSERT) |=> !in_ready)
    else $error("command taken while the previous one is still running");

  // Only shown characters come in runs; every other result closes its item.
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != K_SHOWN) |-> out_last)
    else $error("single result without last");

  // Fields that do not belong to the result kind are zero.
  a_clean_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_kind == K_DELETED) || (out_deleted == '0)) &&
      ((out_kind == K_SHOWN) || (out_char_out == '0)))
    else $error("unused result field not zero");

endmodule

bind gap_buffer_text_editor_unit gbte_chk u_gbte_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_action    (in_ch.action),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_kind     (out_ch.kind),
  .out_deleted  (out_ch.deleted),
  .out_char_out (out_ch.char_out),
  .out_last     (out_ch.last)
);
